// ----- design/utf8v_pkg.sv -----
package utf8v_pkg;

   localparam int unsigned BYTE_W              = 8;
   localparam int unsigned CP_W                = 21;
   localparam int unsigned OFFSET_OUT_W        = 32;
   localparam int unsigned OFFSET_BITS_DEFAULT = 32;

   // lead byte classes
   localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'b1110_0000;
   localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'b1100_0000;
   localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'b1111_0000;
   localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'b1110_0000;
   localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'b1111_1000;
   localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'b1111_0000;
   localparam logic [BYTE_W-1:0] CONT_MASK  = 8'b1100_0000;
   localparam logic [BYTE_W-1:0] CONT_CODE  = 8'b1000_0000;

   localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC2;
   localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;

   localparam logic [CP_W-1:0] CP_MIN3   = 21'h000800;
   localparam logic [CP_W-1:0] CP_MIN4   = 21'h010000;
   localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;
   localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;

   localparam logic [1:0] EXTRA_NONE  = 2'd0;
   localparam logic [1:0] EXTRA_TWO   = 2'd1;
   localparam logic [1:0] EXTRA_THREE = 2'd2;
   localparam logic [1:0] EXTRA_FOUR  = 2'd3;

   // sequence tracking state, positions kept apart since their width is a parameter
   typedef struct packed {
      logic [1:0]        expected;
      logic [1:0]        extra;
      logic [BYTE_W-1:0] lead_val;
      logic [CP_W-1:0]   acc;
      logic              pend;
      logic [BYTE_W-1:0] pend_val;
      logic              err;
      logic [BYTE_W-1:0] err_val;
      logic              non_ascii;
   } seq_type;

   typedef struct packed {
      logic                    is_valid;
      logic                    saw_non_ascii;
      logic [OFFSET_OUT_W-1:0] first_error_offset;
      logic [BYTE_W-1:0]       first_error_byte;
   } verdict_type;

endpackage

// ----- design/utf8v_req_if.sv -----
interface utf8v_req_if import utf8v_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- design/utf8v_rsp_if.sv -----
interface utf8v_rsp_if import utf8v_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic                    is_valid;
   logic                    saw_non_ascii;
   logic [OFFSET_OUT_W-1:0] first_error_offset;
   logic [BYTE_W-1:0]       first_error_byte;

   modport source (output valid, output is_valid, output saw_non_ascii,
                   output first_error_offset, output first_error_byte, input ready);
   modport sink (input valid, input is_valid, input saw_non_ascii,
                 input first_error_offset, input first_error_byte, output ready);
endinterface

// ----- design/utf8v_step.sv -----
module utf8v_step import utf8v_pkg::*; #(
   parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  seq_type                 seq,
   input  logic [OFFSET_BITS-1:0]  byte_count,
   input  logic [OFFSET_BITS-1:0]  lead_pos,
   input  logic [OFFSET_BITS-1:0]  pend_pos,
   input  logic [OFFSET_BITS-1:0]  err_pos,
   input  logic [BYTE_W-1:0]       data_byte,
   input  logic                    last_byte,
   output seq_type                 seq_next,
   output logic [OFFSET_BITS-1:0]  byte_count_next,
   output logic [OFFSET_BITS-1:0]  lead_pos_next,
   output logic [OFFSET_BITS-1:0]  pend_pos_next,
   output logic [OFFSET_BITS-1:0]  err_pos_next,
   output verdict_type             verdict
);

   seq_type                 s;
   logic [OFFSET_BITS-1:0]  lp;
   logic [OFFSET_BITS-1:0]  pp;
   logic [OFFSET_BITS-1:0]  ep;
   logic [1:0]              lead_extra;
   logic [CP_W-1:0]         lead_acc;
   logic [BYTE_W-1:0]       lead_min;
   logic                    hit;
   logic [OFFSET_BITS-1:0]  hit_pos;
   logic [BYTE_W-1:0]       hit_val;
   logic [OFFSET_OUT_W-1:0] err_pos_sat;

   always_comb begin
      s          = seq;
      lp         = lead_pos;
      pp         = pend_pos;
      ep         = err_pos;
      lead_extra = EXTRA_NONE;
      lead_acc   = '0;
      lead_min   = '0;
      hit        = 1'b0;
      hit_pos    = '0;
      hit_val    = '0;

      priority if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
         lead_extra = EXTRA_TWO;
         lead_acc   = CP_W'(data_byte[4:0]);
         lead_min   = LEAD2_MIN;
      end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
         lead_extra = EXTRA_THREE;
         lead_acc   = CP_W'(data_byte[3:0]);
         lead_min   = LEAD3_MIN;
      end else if ((data_byte & LEAD4_MASK) == LEAD4_CODE) begin
         lead_extra = EXTRA_FOUR;
         lead_acc   = CP_W'(data_byte[2:0]);
         lead_min   = LEAD4_MIN;
      end else begin
         lead_extra = EXTRA_NONE;
      end

      if (!seq.err) begin
         if (seq.expected == EXTRA_NONE) begin
            if (data_byte[BYTE_W-1]) begin
               s.non_ascii = 1'b1;
               if (lead_extra == EXTRA_NONE || data_byte < lead_min) begin
                  hit     = 1'b1;
                  hit_pos = byte_count;
                  hit_val = data_byte;
               end else begin
                  s.expected = lead_extra;
                  s.extra    = lead_extra;
                  s.lead_val = data_byte;
                  s.acc      = lead_acc;
                  s.pend     = 1'b0;
                  s.pend_val = '0;
                  lp         = byte_count;
                  pp         = '0;
               end
            end
         end else begin
            if (!seq.pend) begin
               if ((data_byte & CONT_MASK) != CONT_CODE) begin
                  s.pend     = 1'b1;
                  s.pend_val = data_byte;
                  pp         = byte_count;
               end else begin
                  s.acc = {seq.acc[CP_W-7:0], data_byte[5:0]};
               end
            end
            s.expected = seq.expected - 2'd1;
            // sequence complete: report a held bad continuation or check the code point
            if (s.expected == EXTRA_NONE) begin
               if (s.pend) begin
                  hit     = 1'b1;
                  hit_pos = pp;
                  hit_val = s.pend_val;
               end else if ((s.extra == EXTRA_THREE && s.acc < CP_MIN3) ||
                            (s.extra == EXTRA_FOUR && s.acc < CP_MIN4) ||
                            (s.acc >= SURR_LO && s.acc <= SURR_HI) ||
                            (s.acc > CP_MAX)) begin
                  hit     = 1'b1;
                  hit_pos = lp;
                  hit_val = s.lead_val;
               end
               s.pend = 1'b0;
            end
         end
      end

      if (hit) begin
         s.err     = 1'b1;
         s.err_val = hit_val;
         ep        = hit_pos;
      end

      // stream ends inside a sequence: blame the lead
      if (last_byte && !s.err && s.expected != EXTRA_NONE) begin
         s.err     = 1'b1;
         s.err_val = s.lead_val;
         ep        = lp;
      end
   end

   generate
      if (OFFSET_BITS > OFFSET_OUT_W) begin : g_sat
         assign err_pos_sat = (|ep[OFFSET_BITS-1:OFFSET_OUT_W]) ? '1 : ep[OFFSET_OUT_W-1:0];
      end else begin : g_ext
         assign err_pos_sat = OFFSET_OUT_W'(ep);
      end
   endgenerate

   assign verdict.is_valid           = !s.err;
   assign verdict.saw_non_ascii      = s.non_ascii;
   assign verdict.first_error_offset = s.err ? err_pos_sat : '0;
   assign verdict.first_error_byte   = s.err ? s.err_val : '0;

   // start a fresh stream after the last byte
   assign seq_next        = last_byte ? '0 : s;
   assign lead_pos_next   = last_byte ? '0 : lp;
   assign pend_pos_next   = last_byte ? '0 : pp;
   assign err_pos_next    = last_byte ? '0 : ep;
   assign byte_count_next = last_byte ? '0 :
                            (&byte_count) ? byte_count : byte_count + 1'b1;

endmodule

// ----- design/utf8_stream_validator.sv -----
// UTF-8 stream validator.
// req_chan carries one byte per transfer (data_byte) with last_byte marking
// the final byte of a stream. rsp_chan carries one verdict per stream:
// is_valid, saw_non_ascii, and the offset and value of the first error
// (both zero for a valid stream). Ordinary bytes produce no transfer.
// Throughput: one byte per cycle while verdicts are taken. Each byte passes an
// input register, then a single decode step updates the sequence state.
// The verdict is on rsp_chan once the decode step loads it into the output
// register as the last byte leaves the input register.
// The decode step is the only path between the two registers.
// Reset clears all sequence state and the byte offset; the first byte after
// reset, or after a last byte, is offset zero of a new stream.
// When the receiver stalls, the verdict holds in the output register while
// further bytes keep flowing; input stalls only once the next last byte
// reaches the decode step with the previous verdict still not taken.
// Offsets count in OFFSET_BITS bits, saturating; the reported offset
// saturates at the port width.
module utf8_stream_validator import utf8v_pkg::*; #(
   parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   utf8v_req_if.sink   req_chan,
   utf8v_rsp_if.source rsp_chan
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [BYTE_W-1:0]      in_byte_ff;
   logic                   in_last_ff;
   seq_type                seq_ff;
   seq_type                seq_in;
   logic [OFFSET_BITS-1:0] byte_count_ff;
   logic [OFFSET_BITS-1:0] byte_count_in;
   logic [OFFSET_BITS-1:0] lead_pos_ff;
   logic [OFFSET_BITS-1:0] lead_pos_in;
   logic [OFFSET_BITS-1:0] pend_pos_ff;
   logic [OFFSET_BITS-1:0] pend_pos_in;
   logic [OFFSET_BITS-1:0] err_pos_ff;
   logic [OFFSET_BITS-1:0] err_pos_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   verdict_type            rsp_data_ff;
   verdict_type            verdict;
   logic                   advance;
   logic                   load_rsp;
   logic                   take_req;

   // a last byte may only advance when the output register is free or draining
   assign advance  = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign load_rsp = advance && in_last_ff;
   assign req_chan.ready = !in_valid_ff || advance;
   assign take_req = req_chan.valid && req_chan.ready;

   assign in_valid_in  = take_req ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   utf8v_step #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_step (
      .seq             (seq_ff),
      .byte_count      (byte_count_ff),
      .lead_pos        (lead_pos_ff),
      .pend_pos        (pend_pos_ff),
      .err_pos         (err_pos_ff),
      .data_byte       (in_byte_ff),
      .last_byte       (in_last_ff),
      .seq_next        (seq_in),
      .byte_count_next (byte_count_in),
      .lead_pos_next   (lead_pos_in),
      .pend_pos_next   (pend_pos_in),
      .err_pos_next    (err_pos_in),
      .verdict         (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         seq_ff        <= '0;
         byte_count_ff <= '0;
         lead_pos_ff   <= '0;
         pend_pos_ff   <= '0;
         err_pos_ff    <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            seq_ff        <= seq_in;
            byte_count_ff <= byte_count_in;
            lead_pos_ff   <= lead_pos_in;
            pend_pos_ff   <= pend_pos_in;
            err_pos_ff    <= err_pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.last_byte;
      end
      if (load_rsp) begin
         rsp_data_ff <= verdict;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.is_valid           = rsp_data_ff.is_valid;
   assign rsp_chan.saw_non_ascii      = rsp_data_ff.saw_non_ascii;
   assign rsp_chan.first_error_offset = rsp_data_ff.first_error_offset;
   assign rsp_chan.first_error_byte   = rsp_data_ff.first_error_byte;

   // a verdict starts a fresh stream
   a_fresh_stream: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (byte_count_ff == '0 && !seq_ff.err && seq_ff.expected == EXTRA_NONE))
      else $error("state not cleared after verdict");

   // a valid verdict carries no error location
   a_valid_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.is_valid) |->
         (rsp_data_ff.first_error_offset == '0 && rsp_data_ff.first_error_byte == '0))
      else $error("valid verdict with error location");

   // the first error sticks until the stream ends
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (seq_ff.err && !load_rsp) |=> (seq_ff.err && $stable(err_pos_ff)))
      else $error("latched error lost before end of stream");

   // a verdict waiting to be taken is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !load_rsp)
      else $error("verdict overwritten while stalled");

endmodule

// ----- test/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import utf8v_pkg::*;

   localparam int unsigned      OFFSET_BITS  = OFFSET_BITS_DEFAULT;
   localparam logic [63:0]      POS_LIMIT    = (OFFSET_BITS >= 64) ? '1 :
                                               ((64'd1 << OFFSET_BITS) - 64'd1);
   localparam logic [63:0]      REPORT_LIMIT = (64'd1 << OFFSET_OUT_W) - 64'd1;
   localparam int               RANDOM_ITEMS = 1600;

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              last;
      bit                drain_first;
   } byte_item_type;

   logic clock;
   logic reset;

   utf8v_req_if req_chan ();
   utf8v_rsp_if rsp_chan ();

   utf8_stream_validator #(.OFFSET_BITS(OFFSET_BITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   byte_item_type     bytes_to_send[$];
   logic [BYTE_W-1:0] stream_bytes[$];
   verdict_type       verdicts_due[$];
   int                mismatches;
   int                verdicts_seen;
   int                send_gap;
   int                take_gap;
   bit                send_steady;
   bit                take_steady;
   verdict_type       want;

   // decoder state of the stream in progress
   logic [63:0]       stream_pos;
   logic [1:0]        cont_left;
   logic [1:0]        seq_extra;
   logic [63:0]       lead_pos;
   logic [BYTE_W-1:0] lead_byte;
   logic [CP_W-1:0]   cp_acc;
   logic              bad_cont_seen;
   logic [63:0]       bad_cont_pos;
   logic [BYTE_W-1:0] bad_cont_byte;
   logic              err_seen;
   logic [63:0]       err_pos;
   logic [BYTE_W-1:0] err_byte;
   logic              non_ascii_seen;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic clear_stream();
      stream_pos     = '0;
      cont_left      = EXTRA_NONE;
      seq_extra      = EXTRA_NONE;
      lead_pos       = '0;
      lead_byte      = '0;
      cp_acc         = '0;
      bad_cont_seen  = 1'b0;
      bad_cont_pos   = '0;
      bad_cont_byte  = '0;
      err_seen       = 1'b0;
      err_pos        = '0;
      err_byte       = '0;
      non_ascii_seen = 1'b0;
   endtask

   task automatic append_byte(input logic [BYTE_W-1:0] b);
      stream_bytes = {stream_bytes, b};
   endtask

   task automatic note_error(input logic [63:0] pos, input logic [BYTE_W-1:0] b);
      err_seen = 1'b1;
      err_pos  = pos;
      err_byte = b;
   endtask

   // Advance the decoder by one accepted byte; queue a verdict on the last one.
   task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
      logic [63:0]       pos;
      logic [1:0]        n;
      logic [CP_W-1:0]   seed;
      logic [BYTE_W-1:0] lowest;
      verdict_type       v;
      pos = stream_pos;
      if (stream_pos < POS_LIMIT) stream_pos++;
      if (!err_seen) begin
         if (cont_left == EXTRA_NONE) begin
            if (b >= 8'h80) begin
               non_ascii_seen = 1'b1;
               n      = EXTRA_NONE;
               seed   = '0;
               lowest = '0;
               if ((b & LEAD2_MASK) == LEAD2_CODE) begin
                  n = EXTRA_TWO;   seed = CP_W'(b[4:0]); lowest = LEAD2_MIN;
               end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
                  n = EXTRA_THREE; seed = CP_W'(b[3:0]); lowest = LEAD3_MIN;
               end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
                  n = EXTRA_FOUR;  seed = CP_W'(b[2:0]); lowest = LEAD4_MIN;
               end
               if (n == EXTRA_NONE || b < lowest) begin
                  note_error(pos, b);
               end else begin
                  cont_left     = n;
                  seq_extra     = n;
                  lead_pos      = pos;
                  lead_byte     = b;
                  cp_acc        = seed;
                  bad_cont_seen = 1'b0;
                  bad_cont_pos  = '0;
                  bad_cont_byte = '0;
               end
            end
         end else begin
            // hold the first bad continuation until the sequence is complete
            if (!bad_cont_seen) begin
               if ((b & CONT_MASK) != CONT_CODE) begin
                  bad_cont_seen = 1'b1;
                  bad_cont_pos  = pos;
                  bad_cont_byte = b;
               end else begin
                  cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
               end
            end
            cont_left = cont_left - 2'd1;
            if (cont_left == EXTRA_NONE) begin
               if (bad_cont_seen)
                  note_error(bad_cont_pos, bad_cont_byte);
               else if ((seq_extra == EXTRA_THREE && cp_acc < CP_MIN3) ||
                        (seq_extra == EXTRA_FOUR && cp_acc < CP_MIN4) ||
                        (cp_acc >= SURR_LO && cp_acc <= SURR_HI) || cp_acc > CP_MAX)
                  note_error(lead_pos, lead_byte);
               bad_cont_seen = 1'b0;
            end
         end
      end
      if (last) begin
         // a cut-short sequence is blamed on its lead
         if (!err_seen && cont_left != EXTRA_NONE) note_error(lead_pos, lead_byte);
         v.is_valid           = !err_seen;
         v.saw_non_ascii      = non_ascii_seen;
         v.first_error_offset = !err_seen ? '0 :
                                (err_pos > REPORT_LIMIT) ? '1 : err_pos[OFFSET_OUT_W-1:0];
         v.first_error_byte   = err_seen ? err_byte : '0;
         verdicts_due = {verdicts_due, v};
         clear_stream();
      end
   endtask

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] exp_val);
      mismatches++;
      $display("verdict %0d: %s is %0h, expected %0h", verdicts_seen, what, got, exp_val);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CP_W-1:0] pick_cp(input int n);
      logic [CP_W-1:0] cp;
      case (n)
         1: cp = CP_W'($urandom_range(0, 'h7F));
         2: cp = CP_W'($urandom_range('h80, 'h7FF));
         3: begin
            cp = CP_W'($urandom_range('h800, 'hFFFF));
            if (cp >= SURR_LO && cp <= SURR_HI) cp ^= 21'h1000;
         end
         default: cp = CP_W'($urandom_range('h10000, 'h10FFFF));
      endcase
      return cp;
   endfunction

   function automatic int enc_len(input logic [CP_W-1:0] cp);
      if (cp < 'h80) return 1;
      if (cp < 'h800) return 2;
      if (cp < 'h10000) return 3;
      return 4;
   endfunction

   task automatic add_encoded(input logic [CP_W-1:0] cp, input int n);
      case (n)
         1: append_byte({1'b0, cp[6:0]});
         2: begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
         end
         3: begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
         default: begin
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
      endcase
   endtask

   task automatic add_random_char(input bit faulty);
      int              kind;
      int              n;
      int              start;
      logic [CP_W-1:0] cp;
      kind = faulty ? $urandom_range(8, 15) : $urandom_range(0, 7);
      n    = $urandom_range(2, 4);
      case (kind)
         3, 4, 5: add_encoded(pick_cp(kind - 1), kind - 1);
         6: begin
            case ($urandom_range(0, 8))
               0: cp = 'h7F;
               1: cp = 'h80;
               2: cp = 'h7FF;
               3: cp = 'h800;
               4: cp = 'hD7FF;
               5: cp = 'hE000;
               6: cp = 'hFFFF;
               7: cp = 'h10000;
               default: cp = CP_MAX;
            endcase
            add_encoded(cp, enc_len(cp));
         end
         8: add_encoded(pick_cp(n - 1), n);                        // overlong
         9: add_encoded(CP_W'($urandom_range(SURR_LO, SURR_HI)), 3);
         10: add_encoded(CP_W'($urandom_range('h110000, 'h1FFFFF)), 4);   // beyond the top plane
         11: begin
            case ($urandom_range(0, 2))
               0: append_byte(BYTE_W'($urandom_range('h80, 'hBF)));
               1: append_byte(BYTE_W'($urandom_range('hC0, 'hC1)));
               default: append_byte(BYTE_W'($urandom_range('hF5, 'hFF)));
            endcase
         end
         12: begin
            start = stream_bytes.size();
            add_encoded(pick_cp(n), n);
            stream_bytes[start + $urandom_range(1, n - 1)] =
               $urandom_range(0, 1) ? BYTE_W'($urandom_range(0, 'h7F)) :
                                      BYTE_W'($urandom_range('hC0, 'hFF));
         end
         13: begin
            add_encoded(pick_cp(n), n);
            repeat ($urandom_range(1, n - 1)) void'(stream_bytes.pop_back());
         end
         14, 15: repeat ($urandom_range(1, 4)) append_byte(BYTE_W'($urandom_range(0, 255)));
         default: add_encoded(pick_cp(1), 1);
      endcase
   endtask

   task automatic queue_stream(input bit drain_first, input bit terminated);
      byte_item_type item;
      foreach (stream_bytes[i]) begin
         item.data        = stream_bytes[i];
         item.last        = terminated && (i == stream_bytes.size() - 1);
         item.drain_first = drain_first && (i == 0);
         bytes_to_send = {bytes_to_send, item};
      end
      stream_bytes.delete();
   endtask

   task automatic queue_literal(input logic [127:0] packed_bytes, input int n);
      for (int i = n - 1; i >= 0; i--) append_byte(packed_bytes[8*i +: 8]);
      queue_stream(1'b0, 1'b1);
   endtask

   // driver: present the next byte once the previous one has transferred
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            decode_byte(req_chan.data_byte, req_chan.last_byte);
         if (!req_chan.valid || req_chan.ready) begin
            if (bytes_to_send.size() == 0 || send_gap > 0 ||
                (bytes_to_send[0].drain_first && verdicts_due.size() != 0)) begin
               req_chan.valid <= 1'b0;
               if (send_gap > 0) send_gap--;
            end else begin
               req_chan.valid     <= 1'b1;
               req_chan.data_byte <= bytes_to_send[0].data;
               req_chan.last_byte <= bytes_to_send[0].last;
               bytes_to_send.pop_front();
               if ($urandom_range(0, 199) == 0) send_steady = !send_steady;
               send_gap = send_steady ? 0 : pick_gap();
            end
         end
      end
   end

   // monitor: check each verdict transfer against the oldest one due
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         take_gap = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            verdicts_seen++;
            if (verdicts_due.size() == 0) begin
               flag_mismatch("unexpected verdict, is_valid", 64'(rsp_chan.is_valid), 64'd0);
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_chan.is_valid !== want.is_valid)
                  flag_mismatch("is_valid", 64'(rsp_chan.is_valid), 64'(want.is_valid));
               if (rsp_chan.saw_non_ascii !== want.saw_non_ascii)
                  flag_mismatch("saw_non_ascii", 64'(rsp_chan.saw_non_ascii),
                                64'(want.saw_non_ascii));
               if (rsp_chan.first_error_offset !== want.first_error_offset)
                  flag_mismatch("first_error_offset", 64'(rsp_chan.first_error_offset),
                                64'(want.first_error_offset));
               if (rsp_chan.first_error_byte !== want.first_error_byte)
                  flag_mismatch("first_error_byte", 64'(rsp_chan.first_error_byte),
                                64'(want.first_error_byte));
            end
         end
         if ($urandom_range(0, 199) == 0) take_steady = !take_steady;
         if (take_gap > 0) begin
            take_gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if (!take_steady && $urandom_range(0, 3) == 0) take_gap = pick_gap();
         end
      end
   end

   initial begin
      int random_items;
      int chars;
      bit faulty;
      bit first;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready     = 1'b0;
      mismatches         = 0;
      verdicts_seen      = 0;
      send_steady        = 1'b0;
      take_steady        = 1'b0;
      clear_stream();

      queue_literal(128'h00_C280_F48FBFBF_E09FBF_7F, 10);  // overlong sequence amid valid ones
      queue_literal(128'hEDA080, 3);                        // surrogate
      queue_literal(128'hFF, 1);
      queue_literal(128'hC1, 1);
      queue_literal(128'hE241, 2);                          // cut short over a bad continuation
      queue_literal(128'hF0418080, 4);                      // bad continuation
      queue_literal(128'hF4908080, 4);                      // above the top code point

      random_items = 0;
      first        = 1'b1;
      while (random_items < RANDOM_ITEMS) begin
         faulty = $urandom_range(0, 9) < 3;
         chars  = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 10);
         repeat (chars) add_random_char(faulty && $urandom_range(0, 2) == 0);
         random_items += stream_bytes.size();
         queue_stream(first || $urandom_range(0, 40) == 0, 1'b1);
         first = 1'b0;
      end
      // leave a stream open at the end: it must produce nothing
      repeat (3) add_random_char(1'b0);
      queue_stream(1'b0, 1'b0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (bytes_to_send.size() != 0 || req_chan.valid) @(posedge clock);
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
